>>> rtl/pdn_pkg.sv
`timescale 1ns / 1ps
package pdn_pkg;

	// Normalised component width: the largest component lies in [2^30, 2^31)
	localparam int NORM_W     = 31;
	localparam int SQ_W       = 2 * NORM_W;
	localparam int SUM_W      = 64;
	localparam int ROOT_W     = 32;
	localparam int ROOT_STEPS = 32;
	localparam int REM_W      = ROOT_W + 2;
	localparam int COMP_W     = 16;

	// Register port
	localparam int DATA_W   = 32;
	localparam int ADDR_W   = 3;
	localparam int ADDR_LSB = 2;

	typedef logic [ADDR_W-ADDR_LSB-1:0] reg_idx_t;
	localparam reg_idx_t REG_COLORS_SUPPLIED = '0;

	localparam logic KIND_NORMAL = 1'b0;
	localparam logic KIND_COLOR  = 1'b1;

	typedef logic [NORM_W-1:0] norm_t;
	typedef logic [COMP_W-1:0] comp_t;

	typedef struct packed {
		comp_t x;
		comp_t y;
		comp_t z;
		logic  degenerate;
	} vec_res_t;

endpackage

>>> rtl/pdn_sqr.sv
`timescale 1ns / 1ps
module pdn_sqr (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  pdn_pkg::norm_t             a,
	output logic [pdn_pkg::SQ_W-1:0]   sq,
	output logic                       done
);
	import pdn_pkg::*;

	localparam int CNT_W = $clog2(NORM_W + 1);

	logic [2*NORM_W:0] prod_q;
	norm_t             mcand_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [NORM_W+1:0] hi_sum;

	// Add the multiplicand into the upper half when the lowest multiplier bit is set
	assign hi_sum = {1'b0, prod_q[2*NORM_W:NORM_W]} + (prod_q[0] ? {2'b00, mcand_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_q  <= '0;
			mcand_q <= '0;
			cnt_q   <= '0;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				mcand_q <= a;
				prod_q  <= {{(NORM_W+1){1'b0}}, a};
				cnt_q   <= CNT_W'(NORM_W);
				busy_q  <= 1'b1;
			end else if (busy_q) begin
				prod_q <= {hi_sum, prod_q[NORM_W-1:1]};
				cnt_q  <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign sq   = prod_q[SQ_W-1:0];
	assign done = done_q;

endmodule

>>> rtl/pdn_isqrt.sv
`timescale 1ns / 1ps
module pdn_isqrt (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [pdn_pkg::SUM_W-1:0]  s,
	output logic [pdn_pkg::ROOT_W-1:0] root,
	output logic                       done
);
	import pdn_pkg::*;

	localparam int CNT_W = $clog2(ROOT_STEPS + 1);

	logic [SUM_W-1:0]  rad_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [REM_W-1:0]  rem_sh;
	logic [REM_W-1:0]  trial;
	logic              fits;

	// Bring down two radicand bits per step and try root digit one
	assign rem_sh = {rem_q[REM_W-3:0], rad_q[SUM_W-1 -: 2]};
	assign trial  = {root_q, 2'b01};
	assign fits   = (rem_sh >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rad_q  <= '0;
			rem_q  <= '0;
			root_q <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				rad_q  <= s;
				rem_q  <= '0;
				root_q <= '0;
				cnt_q  <= CNT_W'(ROOT_STEPS);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rad_q  <= {rad_q[SUM_W-3:0], 2'b00};
				rem_q  <= fits ? (rem_sh - trial) : rem_sh;
				root_q <= {root_q[ROOT_W-2:0], fits};
				cnt_q  <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign root = root_q;
	assign done = done_q;

endmodule

>>> rtl/pdn_div.sv
`timescale 1ns / 1ps
module pdn_div #(
	parameter int OUT_FRAC_BITS = 15
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  pdn_pkg::norm_t             a,
	input  logic [pdn_pkg::ROOT_W-1:0] n,
	output pdn_pkg::comp_t             comp,
	output logic                       done
);
	import pdn_pkg::*;

	// a <= n, so the quotient of a * 2^F by n is at most 2^F; it is formed in F + 2 bits
	localparam int QW    = OUT_FRAC_BITS + 2;
	localparam int CNT_W = $clog2(QW + 1);
	localparam int XW    = (QW + 1 > COMP_W) ? QW + 1 : COMP_W;
	localparam logic [QW:0] ONE_Q = {{(QW-OUT_FRAC_BITS){1'b0}}, 1'b1, {OUT_FRAC_BITS{1'b0}}};

	logic [ROOT_W-1:0] rem_q;
	logic [ROOT_W-1:0] den_q;
	logic [QW-1:0]     feed_q;
	logic [QW-1:0]     quo_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              fin_q;
	logic              done_q;
	comp_t             comp_q;

	logic [ROOT_W:0] rem_sh;
	logic [ROOT_W:0] rem_sub;
	logic            fits;
	logic [ROOT_W:0] rem_half;
	logic            round_up;
	logic [QW:0]     quo_rnd;
	logic [QW:0]     quo_sat;
	logic [XW-1:0]   quo_ext;

	assign rem_sh  = {rem_q, feed_q[QW-1]};
	assign rem_sub = rem_sh - {1'b0, den_q};
	assign fits    = (rem_sh >= {1'b0, den_q});

	// Rounding: add half the divisor to the final remainder, at most one more quotient unit
	assign rem_half = {1'b0, rem_q} + {2'b00, den_q[ROOT_W-1:1]};
	assign round_up = (rem_half >= {1'b0, den_q});
	assign quo_rnd  = {1'b0, quo_q} + {{QW{1'b0}}, round_up};
	assign quo_sat  = (quo_rnd > ONE_Q) ? ONE_Q : quo_rnd;
	assign quo_ext  = XW'(quo_sat);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			den_q  <= '0;
			feed_q <= '0;
			quo_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			comp_q <= '0;
		end else begin
			done_q <= 1'b0;
			fin_q  <= 1'b0;
			if (start) begin
				rem_q  <= {{(ROOT_W-NORM_W+2){1'b0}}, a[NORM_W-1:2]};
				feed_q <= {a[1:0], {OUT_FRAC_BITS{1'b0}}};
				den_q  <= n;
				quo_q  <= '0;
				cnt_q  <= CNT_W'(QW);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q  <= fits ? rem_sub[ROOT_W-1:0] : rem_sh[ROOT_W-1:0];
				quo_q  <= {quo_q[QW-2:0], fits};
				feed_q <= {feed_q[QW-2:0], 1'b0};
				cnt_q  <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end else if (fin_q) begin
				comp_q <= quo_ext[COMP_W-1:0];
				done_q <= 1'b1;
			end
		end
	end

	assign comp = comp_q;
	assign done = done_q;

endmodule

>>> rtl/pdn_norm.sv
`timescale 1ns / 1ps
module pdn_norm #(
	parameter int COORD_WIDTH   = 32,
	parameter int OUT_FRAC_BITS = 15
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [COORD_WIDTH:0]   ax,
	input  logic [COORD_WIDTH:0]   ay,
	input  logic [COORD_WIDTH:0]   az,
	output pdn_pkg::vec_res_t      res,
	output logic                   done
);
	import pdn_pkg::*;

	localparam int DW = COORD_WIDTH + 1;
	localparam int AW = (DW > NORM_W) ? DW : NORM_W;

	typedef enum logic [2:0] {
		N_IDLE,
		N_SCALE,
		N_SQR,
		N_SUM,
		N_ROOT,
		N_DIV
	} norm_state_t;

	norm_state_t state_q;
	logic [AW-1:0] ax_q, ay_q, az_q;
	logic [SUM_W-1:0] sum_q;
	logic go_sqr_q, go_root_q, go_div_q;
	logic done_q;
	vec_res_t res_q;

	logic [AW-1:0]     or_v;
	logic              too_big;
	logic              too_small;
	logic [SQ_W-1:0]   sq_x, sq_y, sq_z;
	logic [2:0]        sq_done;
	logic [ROOT_W-1:0] root;
	logic              root_done;
	comp_t             cx, cy, cz;
	logic [2:0]        div_done;

	// The leading bit of the OR is the leading bit of the largest component
	assign or_v      = ax_q | ay_q | az_q;
	assign too_big   = ((or_v >> NORM_W) != '0);
	assign too_small = !or_v[NORM_W-1];

	pdn_sqr u_sqr_x (.clk, .arst_n, .start(go_sqr_q), .a(ax_q[NORM_W-1:0]), .sq(sq_x),
		.done(sq_done[0]));
	pdn_sqr u_sqr_y (.clk, .arst_n, .start(go_sqr_q), .a(ay_q[NORM_W-1:0]), .sq(sq_y),
		.done(sq_done[1]));
	pdn_sqr u_sqr_z (.clk, .arst_n, .start(go_sqr_q), .a(az_q[NORM_W-1:0]), .sq(sq_z),
		.done(sq_done[2]));

	pdn_isqrt u_isqrt (.clk, .arst_n, .start(go_root_q), .s(sum_q), .root(root),
		.done(root_done));

	pdn_div #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_div_x (.clk, .arst_n, .start(go_div_q),
		.a(ax_q[NORM_W-1:0]), .n(root), .comp(cx), .done(div_done[0]));
	pdn_div #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_div_y (.clk, .arst_n, .start(go_div_q),
		.a(ay_q[NORM_W-1:0]), .n(root), .comp(cy), .done(div_done[1]));
	pdn_div #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_div_z (.clk, .arst_n, .start(go_div_q),
		.a(az_q[NORM_W-1:0]), .n(root), .comp(cz), .done(div_done[2]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= N_IDLE;
			ax_q      <= '0;
			ay_q      <= '0;
			az_q      <= '0;
			sum_q     <= '0;
			go_sqr_q  <= 1'b0;
			go_root_q <= 1'b0;
			go_div_q  <= 1'b0;
			done_q    <= 1'b0;
			res_q     <= '0;
		end else begin
			go_sqr_q  <= 1'b0;
			go_root_q <= 1'b0;
			go_div_q  <= 1'b0;
			done_q    <= 1'b0;
			case (state_q)
				N_IDLE: begin
					if (start) begin
						ax_q <= AW'(ax);
						ay_q <= AW'(ay);
						az_q <= AW'(az);
						if ((ax | ay | az) == '0) begin
							res_q.x          <= '0;
							res_q.y          <= '0;
							res_q.z          <= '0;
							res_q.degenerate <= 1'b1;
							done_q           <= 1'b1;
						end else begin
							state_q <= N_SCALE;
						end
					end
				end
				N_SCALE: begin
					// Shift all three alike until the largest lies in [2^30, 2^31)
					if (too_big) begin
						ax_q <= ax_q >> 1;
						ay_q <= ay_q >> 1;
						az_q <= az_q >> 1;
					end else if (too_small) begin
						ax_q <= ax_q << 1;
						ay_q <= ay_q << 1;
						az_q <= az_q << 1;
					end else begin
						go_sqr_q <= 1'b1;
						state_q  <= N_SQR;
					end
				end
				N_SQR: begin
					if (&sq_done) begin
						sum_q   <= SUM_W'(sq_x) + SUM_W'(sq_y);
						state_q <= N_SUM;
					end
				end
				N_SUM: begin
					sum_q     <= sum_q + SUM_W'(sq_z);
					go_root_q <= 1'b1;
					state_q   <= N_ROOT;
				end
				N_ROOT: begin
					if (root_done) begin
						go_div_q <= 1'b1;
						state_q  <= N_DIV;
					end
				end
				N_DIV: begin
					if (&div_done) begin
						res_q.x          <= cx;
						res_q.y          <= cy;
						res_q.z          <= cz;
						res_q.degenerate <= 1'b0;
						done_q           <= 1'b1;
						state_q          <= N_IDLE;
					end
				end
				default: begin
					state_q <= N_IDLE;
				end
			endcase
		end
	end

	assign res  = res_q;
	assign done = done_q;

endmodule

>>> rtl/polyline_direction_normals_unit.sv
`timescale 1ns / 1ps
// Polyline direction normals. Points arrive one transaction at a time, the end of each line
// marked by last_in_line; every point yields the normalised absolute step from its
// predecessor (the first point reuses the step to the second, so it appears with the
// second point), and a line end also yields the normalised absolute first-to-last vector
// unless colors_supplied is set. Components are unsigned with OUT_FRAC_BITS fraction bits.
// All vectors go through one shared bit-serial engine: a normalising shift of one bit per
// cycle (up to 30 left or COORD_WIDTH-31 right), three one-bit-per-cycle squarers, a
// 32-step square root and three restoring dividers. Each result is loaded into the output
// register when it is free; the repeated normal of a second point is reused, not recomputed.
// in_stall is high until the item's last result sits in the output register (for a first point
// that yields none, until its steps are formed); that result may wait there while the next transaction is taken.
module polyline_direction_normals_unit #(
	parameter int COORD_WIDTH   = 32,
	parameter int OUT_FRAC_BITS = 15
) (
	input  logic                        clk,
	input  logic                        arst_n,

	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [pdn_pkg::ADDR_W-1:0]  paddr,
	input  logic [pdn_pkg::DATA_W-1:0]  pwdata,
	output logic [pdn_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,

	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic signed [COORD_WIDTH-1:0] x,
	input  logic signed [COORD_WIDTH-1:0] y,
	input  logic signed [COORD_WIDTH-1:0] z,
	input  logic                        last_in_line,

	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        kind,
	output pdn_pkg::comp_t              comp_x,
	output pdn_pkg::comp_t              comp_y,
	output pdn_pkg::comp_t              comp_z,
	output logic                        degenerate,
	output logic                        last
);
	import pdn_pkg::*;

	localparam int DW = COORD_WIDTH + 1;

	typedef enum logic [2:0] {
		T_IDLE,
		T_DIFF,
		T_RUN_N,
		T_EMIT_N,
		T_RUN_C,
		T_EMIT_C
	} top_state_t;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic [DW-1:0] diff_t;

	function automatic diff_t abs_diff(input coord_t a, input coord_t b);
		diff_t dd;
		dd = {a[COORD_WIDTH-1], a} - {b[COORD_WIDTH-1], b};
		return dd[DW-1] ? DW'(~dd + DW'(1)) : dd;
	endfunction

	// Register port
	logic     colors_q;
	reg_idx_t reg_idx;

	assign reg_idx = paddr[ADDR_W-1:ADDR_LSB];
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			colors_q <= 1'b0;
		end else if (psel && penable && pwrite && pready) begin
			if (reg_idx == REG_COLORS_SUPPLIED) begin
				colors_q <= pwdata[0];
			end
		end
	end

	always_comb begin
		case (reg_idx)
			REG_COLORS_SUPPLIED: prdata = {{(DATA_W-1){1'b0}}, colors_q};
			default:             prdata = '0;
		endcase
	end

	// Point sequencing
	top_state_t state_q;
	coord_t     pt_x_q, pt_y_q, pt_z_q;
	coord_t     prev_x_q, prev_y_q, prev_z_q;
	coord_t     first_x_q, first_y_q, first_z_q;
	logic [1:0] seen_q;
	logic       zero_q;
	logic [1:0] nrm_cnt_q;
	logic       color_q;
	diff_t      d_x_q, d_y_q, d_z_q;
	diff_t      c_x_q, c_y_q, c_z_q;
	logic       eng_go_q;
	logic       eng_sel_c_q;
	vec_res_t   res_q;
	logic       out_valid_q;
	logic       kind_q;
	vec_res_t   out_q;
	logic       last_q;

	logic     accept;
	logic     slot_free;
	vec_res_t eng_res;
	logic     eng_done;

	assign in_stall  = (state_q != T_IDLE);
	assign accept    = in_valid && !in_stall;
	assign slot_free = !out_valid_q || !out_stall;

	pdn_norm #(.COORD_WIDTH(COORD_WIDTH), .OUT_FRAC_BITS(OUT_FRAC_BITS)) u_norm (
		.clk,
		.arst_n,
		.start (eng_go_q),
		.ax    (eng_sel_c_q ? c_x_q : d_x_q),
		.ay    (eng_sel_c_q ? c_y_q : d_y_q),
		.az    (eng_sel_c_q ? c_z_q : d_z_q),
		.res   (eng_res),
		.done  (eng_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= T_IDLE;
			pt_x_q      <= '0;
			pt_y_q      <= '0;
			pt_z_q      <= '0;
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			prev_z_q    <= '0;
			first_x_q   <= '0;
			first_y_q   <= '0;
			first_z_q   <= '0;
			seen_q      <= '0;
			zero_q      <= 1'b0;
			nrm_cnt_q   <= '0;
			color_q     <= 1'b0;
			d_x_q       <= '0;
			d_y_q       <= '0;
			d_z_q       <= '0;
			c_x_q       <= '0;
			c_y_q       <= '0;
			c_z_q       <= '0;
			eng_go_q    <= 1'b0;
			eng_sel_c_q <= 1'b0;
			res_q       <= '0;
			out_valid_q <= 1'b0;
			kind_q      <= KIND_NORMAL;
			out_q       <= '0;
			last_q      <= 1'b0;
		end else begin
			eng_go_q <= 1'b0;
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				T_IDLE: begin
					if (accept) begin
						pt_x_q  <= x;
						pt_y_q  <= y;
						pt_z_q  <= z;
						color_q <= last_in_line && !colors_q;
						if (seen_q == 2'd0) begin
							first_x_q <= x;
							first_y_q <= y;
							first_z_q <= z;
							zero_q    <= 1'b1;
							nrm_cnt_q <= last_in_line ? 2'd1 : 2'd0;
							seen_q    <= last_in_line ? 2'd0 : 2'd1;
						end else begin
							zero_q    <= 1'b0;
							// A second point also carries the first point's normal
							nrm_cnt_q <= (seen_q == 2'd1) ? 2'd2 : 2'd1;
							seen_q    <= last_in_line ? 2'd0 : 2'd2;
						end
						state_q <= T_DIFF;
					end
				end
				T_DIFF: begin
					d_x_q    <= zero_q ? '0 : abs_diff(prev_x_q, pt_x_q);
					d_y_q    <= zero_q ? '0 : abs_diff(prev_y_q, pt_y_q);
					d_z_q    <= zero_q ? '0 : abs_diff(prev_z_q, pt_z_q);
					c_x_q    <= abs_diff(first_x_q, pt_x_q);
					c_y_q    <= abs_diff(first_y_q, pt_y_q);
					c_z_q    <= abs_diff(first_z_q, pt_z_q);
					prev_x_q <= pt_x_q;
					prev_y_q <= pt_y_q;
					prev_z_q <= pt_z_q;
					if (nrm_cnt_q != 2'd0) begin
						eng_go_q    <= 1'b1;
						eng_sel_c_q <= 1'b0;
						state_q     <= T_RUN_N;
					end else if (color_q) begin
						eng_go_q    <= 1'b1;
						eng_sel_c_q <= 1'b1;
						state_q     <= T_RUN_C;
					end else begin
						state_q <= T_IDLE;
					end
				end
				T_RUN_N: begin
					if (eng_done) begin
						res_q   <= eng_res;
						state_q <= T_EMIT_N;
					end
				end
				T_EMIT_N: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						kind_q      <= KIND_NORMAL;
						out_q       <= res_q;
						last_q      <= (nrm_cnt_q == 2'd1) && !color_q;
						nrm_cnt_q   <= nrm_cnt_q - 2'd1;
						if (nrm_cnt_q == 2'd1) begin
							if (color_q) begin
								eng_go_q    <= 1'b1;
								eng_sel_c_q <= 1'b1;
								state_q     <= T_RUN_C;
							end else begin
								state_q <= T_IDLE;
							end
						end
					end
				end
				T_RUN_C: begin
					if (eng_done) begin
						res_q   <= eng_res;
						state_q <= T_EMIT_C;
					end
				end
				T_EMIT_C: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						kind_q      <= KIND_COLOR;
						out_q       <= res_q;
						last_q      <= 1'b1;
						state_q     <= T_IDLE;
					end
				end
				default: begin
					state_q <= T_IDLE;
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign kind       = kind_q;
	assign comp_x     = out_q.x;
	assign comp_y     = out_q.y;
	assign comp_z     = out_q.z;
	assign degenerate = out_q.degenerate;
	assign last       = last_q;

endmodule

>>> rtl/pdn_chk.sv
`timescale 1ns / 1ps
module pdn_chk (
	input logic           clk,
	input logic           arst_n,
	input logic           in_valid,
	input logic           in_stall,
	input logic           out_valid,
	input logic           out_stall,
	input logic           kind,
	input pdn_pkg::comp_t comp_x,
	input pdn_pkg::comp_t comp_y,
	input pdn_pkg::comp_t comp_z,
	input logic           degenerate,
	input logic           last
);
	import pdn_pkg::*;

	// An accepted point keeps the block busy for at least the following cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken again straight after a transaction");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(kind) && $stable(comp_x)
			&& $stable(comp_y) && $stable(comp_z) && $stable(degenerate) && $stable(last))
		else $error("stalled result changed");

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> comp_x == '0 && comp_y == '0 && comp_z == '0)
		else $error("degenerate result with non-zero components");

	// A line colour is always the closing result of its point
	a_color_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_COLOR |-> last)
		else $error("line colour not marked last");

endmodule

bind polyline_direction_normals_unit pdn_chk u_pdn_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.kind       (kind),
	.comp_x     (comp_x),
	.comp_y     (comp_y),
	.comp_z     (comp_z),
	.degenerate (degenerate),
	.last       (last)
);

>>> test/tb_polyline_direction_normals_unit.sv
`timescale 1ns / 1ps
module tb_polyline_direction_normals_unit;
	import pdn_pkg::*;

	localparam int COORD_WIDTH   = 32;
	localparam int OUT_FRAC_BITS = 15;
	localparam int SETTLE_CYCLES = 300;

	localparam reg_idx_t REG_UNUSED = reg_idx_t'(1);

	localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = 32'sh8000_0000;

	typedef longint unsigned u64_t;
	typedef logic signed [COORD_WIDTH-1:0] coord_t;

	typedef struct {
		logic  kind;
		comp_t cx;
		comp_t cy;
		comp_t cz;
		logic  degen;
		logic  last;
	} vector_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [ADDR_W-1:0]  paddr = '0;
	logic [DATA_W-1:0]  pwdata = '0;
	logic [DATA_W-1:0]  prdata;
	logic               pready;

	logic   in_valid = 1'b0;
	logic   in_stall;
	coord_t x = '0;
	coord_t y = '0;
	coord_t z = '0;
	logic   last_in_line = 1'b0;

	logic  out_valid;
	logic  out_stall = 1'b0;
	logic  kind;
	comp_t comp_x;
	comp_t comp_y;
	comp_t comp_z;
	logic  degenerate;
	logic  last;

	// Predictor state
	longint line_start[3];
	longint prev_point[3];
	int     points_in_line;
	logic   colors_on;

	vector_result_t expected_vectors[$];
	int errors = 0;
	int idle_pct = 0;
	int stall_pct = 0;

	polyline_direction_normals_unit #(
		.COORD_WIDTH(COORD_WIDTH),
		.OUT_FRAC_BITS(OUT_FRAC_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.x(x),
		.y(y),
		.z(z),
		.last_in_line(last_in_line),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind(kind),
		.comp_x(comp_x),
		.comp_y(comp_y),
		.comp_z(comp_z),
		.degenerate(degenerate),
		.last(last)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	function automatic u64_t int_sqrt(u64_t v);
		u64_t root = 0;
		u64_t bitpos = 64'h4000_0000_0000_0000;
		while (bitpos > v)
			bitpos >>= 2;
		while (bitpos != 0) begin
			if (v >= root + bitpos) begin
				v -= root + bitpos;
				root = (root >> 1) + bitpos;
			end else begin
				root >>= 1;
			end
			bitpos >>= 2;
		end
		return root;
	endfunction

	function automatic u64_t abs_gap(longint a, longint b);
		return (a >= b) ? u64_t'(a - b) : u64_t'(b - a);
	endfunction

	// Scale so the largest component sits in [2^30, 2^31), then divide by the rounded-down root
	function automatic vector_result_t unit_vector(logic vkind, u64_t d[3]);
		u64_t a[3];
		u64_t peak, sumsq, len, q;
		comp_t c[3];
		vector_result_t r;
		a = d;
		peak = a[0];
		if (a[1] > peak) peak = a[1];
		if (a[2] > peak) peak = a[2];
		r.kind = vkind;
		r.last = 1'b0;
		r.degen = 1'b0;
		c = '{default: '0};
		if (peak == 0) begin
			r.degen = 1'b1;
		end else begin
			while (peak >= 64'h8000_0000) begin
				peak >>= 1;
				foreach (a[i]) a[i] >>= 1;
			end
			while (peak < 64'h4000_0000) begin
				peak <<= 1;
				foreach (a[i]) a[i] <<= 1;
			end
			sumsq = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
			len = int_sqrt(sumsq);
			foreach (a[i]) begin
				q = ((a[i] << OUT_FRAC_BITS) + (len >> 1)) / len;
				if (q > (u64_t'(1) << OUT_FRAC_BITS))
					q = u64_t'(1) << OUT_FRAC_BITS;
				c[i] = q[COMP_W-1:0];
			end
		end
		r.cx = c[0];
		r.cy = c[1];
		r.cz = c[2];
		return r;
	endfunction

	function automatic void predict_point(coord_t px, coord_t py, coord_t pz, logic eol);
		longint p[3];
		u64_t d[3];
		vector_result_t batch[$];
		p = '{longint'(px), longint'(py), longint'(pz)};
		if (points_in_line == 0) begin
			line_start = p;
			if (eol) begin
				d = '{0, 0, 0};
				batch.insert(batch.size(), unit_vector(KIND_NORMAL, d));
			end else begin
				points_in_line = 1;
			end
		end else begin
			foreach (d[i]) d[i] = abs_gap(prev_point[i], p[i]);
			// the opening point borrows the step to the second
			if (points_in_line == 1)
				batch.insert(batch.size(), unit_vector(KIND_NORMAL, d));
			batch.insert(batch.size(), unit_vector(KIND_NORMAL, d));
			points_in_line = 2;
		end
		if (eol) begin
			if (!colors_on) begin
				foreach (d[i]) d[i] = abs_gap(line_start[i], p[i]);
				batch.insert(batch.size(), unit_vector(KIND_COLOR, d));
			end
			points_in_line = 0;
		end
		prev_point = p;
		if (batch.size() > 0)
			batch[batch.size()-1].last = 1'b1;
		foreach (batch[i]) expected_vectors.insert(expected_vectors.size(), batch[i]);
	endfunction

	function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk) begin : check_results
		vector_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_vectors.size() == 0) begin
				$error("result with nothing outstanding: kind %0d", kind);
				errors++;
			end else begin
				want = expected_vectors.pop_front();
				check_field("kind", want.kind, kind);
				check_field("comp_x", want.cx, comp_x);
				check_field("comp_y", want.cy, comp_y);
				check_field("comp_z", want.cz, comp_z);
				check_field("degenerate", want.degen, degenerate);
				check_field("last", want.last, last);
			end
		end
	end

	task automatic write_reg(reg_idx_t idx, logic [DATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'(idx) << ADDR_LSB;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_COLORS_SUPPLIED)
			colors_on = value[0];
		// hold the bus idle before the next access
		@(posedge clk);
	endtask

	task automatic send_point(coord_t px, coord_t py, coord_t pz, logic eol);
		if ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		in_valid <= 1'b1;
		x <= px;
		y <= py;
		z <= pz;
		last_in_line <= eol;
		do @(posedge clk); while (in_stall);
		predict_point(px, py, pz, eol);
	endtask

	// Hold off until every outstanding result is back, then let the engine settle
	task automatic drain_results();
		in_valid <= 1'b0;
		while (expected_vectors.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic test_coordinate_extremes();
		idle_pct = 0;
		stall_pct = 0;
		// single-point line: degenerate normal then degenerate colour
		send_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);
		send_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);
		send_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);
		send_point(COORD_MIN, '0, COORD_MAX, 1'b0);
		send_point(COORD_MAX, COORD_MIN, '0, 1'b1);
		send_point('0, '0, COORD_MIN, 1'b1);
		drain_results();
	endtask

	task automatic test_small_steps_and_repeats();
		stall_pct = 50;
		send_point('0, '0, '0, 1'b0);
		send_point(32'sd1, '0, '0, 1'b0);
		// repeated point gives a zero step
		send_point(32'sd1, '0, '0, 1'b0);
		send_point('0, -32'sd1, 32'sd2, 1'b0);
		send_point(32'sd3, 32'sd4, '0, 1'b0);
		// closed line: first and last coincide
		send_point('0, '0, '0, 1'b1);
		send_point(32'sh0001_0000, -32'sh0002_0000, 32'sh0000_8000, 1'b0);
		send_point(32'sh0001_0000, -32'sh0002_0000, 32'sh0000_8000, 1'b1);
		drain_results();
	endtask

	task automatic test_colour_register();
		stall_pct = 0;
		write_reg(REG_COLORS_SUPPLIED, 32'h0000_0001);
		send_point(32'sd5, 32'sd5, 32'sd5, 1'b1);
		send_point(32'sd7, -32'sd9, 32'sd11, 1'b0);
		send_point(-32'sd7, 32'sd9, 32'sd100, 1'b1);
		drain_results();
		// writes beyond the one register must not disturb it
		write_reg(REG_UNUSED, 32'h0000_0000);
		send_point(32'sd1, 32'sd2, 32'sd3, 1'b1);
		drain_results();
		write_reg(REG_COLORS_SUPPLIED, 32'hFFFF_FFFE);
		write_reg(REG_UNUSED, 32'hFFFF_FFFF);
		send_point(32'sd1, 32'sd2, 32'sd3, 1'b0);
		send_point(32'sd4, 32'sd6, 32'sd8, 1'b1);
		drain_results();
	endtask

	task automatic test_random_lines(int n_points, int send_idle, int recv_stall, logic colors);
		coord_t cx, cy, cz;
		int sent;
		int len;
		int mode;
		sent = 0;
		cx = $urandom;
		cy = $urandom;
		cz = $urandom;
		write_reg(REG_COLORS_SUPPLIED, ($urandom & ~32'h1) | DATA_W'(colors));
		idle_pct = send_idle;
		stall_pct = recv_stall;
		while (sent < n_points) begin
			len = $urandom_range(1, 5);
			for (int k = 0; k < len; k++) begin
				mode = $urandom_range(9);
				if (mode < 4) begin
					cx = $urandom;
					cy = $urandom;
					cz = $urandom;
				end else if (mode < 9) begin
					cx = cx + ((int'($urandom_range(6)) - 3) <<< $urandom_range(20));
					cy = cy + ((int'($urandom_range(6)) - 3) <<< $urandom_range(20));
					cz = cz + ((int'($urandom_range(6)) - 3) <<< $urandom_range(20));
				end
				send_point(cx, cy, cz, k == len - 1);
				sent++;
			end
		end
		drain_results();
	endtask

	initial begin
		line_start = '{0, 0, 0};
		prev_point = '{0, 0, 0};
		points_in_line = 0;
		colors_on = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_coordinate_extremes();
		test_small_steps_and_repeats();
		test_colour_register();
		test_random_lines(22, 0, 0, 1'b0);
		test_random_lines(22, 80, 0, 1'b1);
		test_random_lines(22, 0, 80, 1'b0);
		test_random_lines(22, 31, 31, 1'b0);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
